### rtl/bpra_pkg.sv
// Shared types and constants of the bitmap page run allocator.
// Depends on nothing; every other file of the block uses it.
package bpra_pkg;

   // Default geometry of the managed window
   localparam int DEF_PAGE_BYTES = 4096;
   localparam int DEF_NUM_PAGES  = 1024;

   // Fixed field widths of the transactions
   localparam int SIZE_W   = 23;
   localparam int ADDR_W   = 32;
   localparam int STATUS_W = 2;

   // The usage map is stored and scanned one word at a time
   localparam int WORD_BITS = 32;
   localparam int LANE_W    = $clog2(WORD_BITS);

   // Request modes
   localparam logic MODE_ALLOC = 1'b0;
   localparam logic MODE_FREE  = 1'b1;

   // Result codes
   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_ZERO_SIZE = 2'd1,
      STATUS_NO_RUN    = 2'd2,
      STATUS_OUTSIDE   = 2'd3
   } status_type;

   // Outcome of scanning one map word
   typedef struct packed {
      logic              hit;
      logic [LANE_W-1:0] lane;
   } scan_result_type;

endpackage

### rtl/bpra_req_if.sv
// Request channel of the bitmap page run allocator: valid, ready and payload.
// Depends on bpra_pkg for the field widths.
interface bpra_req_if;
   logic                        valid;
   logic                        ready;
   logic                        mode;
   logic [bpra_pkg::SIZE_W-1:0] size_bytes;
   logic [bpra_pkg::ADDR_W-1:0] region_address;

   modport source (output valid, output mode, output size_bytes, output region_address,
                   input ready);
   modport sink (input valid, input mode, input size_bytes, input region_address,
                 output ready);
   modport monitor (input valid, input ready, input mode, input size_bytes,
                    input region_address);
endinterface

### rtl/bpra_rsp_if.sv
// Response channel of the bitmap page run allocator: valid, ready and payload.
// Depends on bpra_pkg for the field widths.
interface bpra_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [bpra_pkg::ADDR_W-1:0]   granted_address;
   logic [bpra_pkg::STATUS_W-1:0] status;

   modport source (output valid, output granted_address, output status, input ready);
   modport sink (input valid, input granted_address, input status, output ready);
   modport monitor (input valid, input ready, input granted_address, input status);
endinterface

### rtl/bpra_run_scan.sv
// Word scan unit: finds the first page in one map word that completes a free run.
// Depends on bpra_pkg; used by the top level once per word during a search.
module bpra_run_scan #(
   parameter int NUM_PAGES = bpra_pkg::DEF_NUM_PAGES
) (
   input  logic [bpra_pkg::WORD_BITS-1:0]    used_word,
   input  logic [$clog2(NUM_PAGES + 1)-1:0]  carry_run,
   input  logic [$clog2(NUM_PAGES + 1)-1:0]  pages,
   output logic [$clog2(NUM_PAGES + 1)-1:0]  carry_out,
   output bpra_pkg::scan_result_type         result
);
   import bpra_pkg::*;

   localparam int CNT_W = $clog2(NUM_PAGES + 1);

   logic [CNT_W-1:0]     run_len [WORD_BITS];
   logic [WORD_BITS-1:0] hit_vec;

   // Position of the highest used page at or below a lane
   function automatic logic [LANE_W:0] last_used(input logic [WORD_BITS-1:0] w,
                                                 input int upto);
      logic              any;
      logic [LANE_W-1:0] pos;
      any = 1'b0;
      pos = '0;
      for (int j = 0; j < WORD_BITS; j++) begin
         if (j <= upto && w[j]) begin
            any = 1'b1;
            pos = LANE_W'(j);
         end
      end
      return {any, pos};
   endfunction

   // Length of the free run that ends at each lane, including a run carried in
   always_comb begin : lane_eval
      logic [LANE_W:0] lu;
      lu = '0;
      for (int i = 0; i < WORD_BITS; i++) begin
         lu = last_used(used_word, i);
         if (lu[LANE_W]) begin
            run_len[i] = CNT_W'(i) - CNT_W'(lu[LANE_W-1:0]);
         end else begin
            run_len[i] = carry_run + CNT_W'(i) + CNT_W'(1);
         end
         hit_vec[i] = !used_word[i] && (run_len[i] >= pages);
      end
   end

   // Pick the lowest lane where the run reaches the requested length
   always_comb begin : first_hit
      result.hit  = |hit_vec;
      result.lane = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (hit_vec[i]) begin
            result.lane = LANE_W'(i);
         end
      end
   end

   assign carry_out = run_len[WORD_BITS-1];

endmodule

### rtl/bitmap_page_run_allocator.sv
// An allocate scans the map word by word until a run is found, then rewrites the words the run
// spans; a free rewrites only the words it spans. Zero size, oversize, outside-window requests and
// allocates with no run are answered without changing the map.
// Throughput: one transaction at a time; the next is taken once the response register is loaded.
// Reset: synchronous; a clearing pass then zeroes the map one word at a time, not ready meanwhile.
// Depends on bpra_pkg, bpra_req_if, bpra_rsp_if and bpra_run_scan.
module bitmap_page_run_allocator #(
   parameter int PAGE_BYTES = bpra_pkg::DEF_PAGE_BYTES,
   parameter int NUM_PAGES  = bpra_pkg::DEF_NUM_PAGES
) (
   input  logic                        clock,
   input  logic                        reset,
   bpra_req_if.sink                    req_chan,
   bpra_rsp_if.source                  rsp_chan,
   input  logic                        csr_write_enable,
   input  logic [bpra_pkg::ADDR_W-1:0] csr_write_data
);
   import bpra_pkg::*;

   // Page size must be a power of two, which the block does not check; page arithmetic is shifting
   localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
   localparam int NUM_WORDS  = (NUM_PAGES + WORD_BITS - 1) / WORD_BITS;
   localparam int WIDX_W     = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
   localparam int WCNT_W     = WIDX_W + 1;
   localparam int PIDX_W     = WIDX_W + LANE_W;
   localparam int CNT_W      = $clog2(NUM_PAGES + 1);
   localparam int PG_W       = SIZE_W + 1 - PAGE_SHIFT;
   localparam int FIRST_W    = ADDR_W - PAGE_SHIFT;
   localparam int CMP_W      = ADDR_W + 1;

   localparam logic [WCNT_W-1:0] LAST_WORD   = WCNT_W'(NUM_WORDS - 1);
   localparam logic [CMP_W-1:0]  NUM_PAGES_C = CMP_W'(NUM_PAGES);
   localparam logic [PIDX_W:0]   PAD_START   = (PIDX_W + 1)'(NUM_PAGES);
   localparam logic [SIZE_W:0]   ROUND_UP    = (SIZE_W + 1)'(PAGE_BYTES - 1);

   typedef enum logic [6:0] {
      ST_CLEAR  = 7'b0000001,
      ST_IDLE   = 7'b0000010,
      ST_CHECK  = 7'b0000100,
      ST_SEARCH = 7'b0001000,
      ST_PREP   = 7'b0010000,
      ST_APPLY  = 7'b0100000,
      ST_DONE   = 7'b1000000
   } state_type;

   state_type             state_ff, state_in;
   logic [ADDR_W-1:0]     base_ff, base_in;
   logic                  mode_ff, mode_in;
   logic [SIZE_W-1:0]     size_ff, size_in;
   logic [ADDR_W-1:0]     addr_ff, addr_in;
   logic [PG_W-1:0]       pages_ff, pages_in;
   logic [FIRST_W-1:0]    first_ff, first_in;
   logic [PIDX_W-1:0]     lo_ff, lo_in;
   logic [PIDX_W-1:0]     hi_ff, hi_in;
   logic [WCNT_W-1:0]     iss_ff, iss_in;
   logic [WIDX_W-1:0]     proc_ff, proc_in;
   logic                  dv_ff, dv_in;
   logic [CNT_W-1:0]      carry_ff, carry_in;
   logic [WCNT_W-1:0]     clr_ff, clr_in;
   status_type            status_ff, status_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]     rsp_addr_ff, rsp_addr_in;
   status_type            rsp_status_ff, rsp_status_in;
   logic [WORD_BITS-1:0]  rd_data_ff;

   logic [WORD_BITS-1:0]  map_mem [NUM_WORDS];

   logic                  rd_en;
   logic [WIDX_W-1:0]     rd_addr;
   logic                  wr_en;
   logic [WIDX_W-1:0]     wr_addr;
   logic [WORD_BITS-1:0]  wr_data;

   logic [SIZE_W:0]       size_round;
   logic [WORD_BITS-1:0]  pad_mask;
   logic [WORD_BITS-1:0]  run_mask;
   logic [WORD_BITS-1:0]  scan_word;
   logic [CNT_W-1:0]      scan_carry;
   scan_result_type       scan_res;
   logic [CMP_W-1:0]      end_excl;
   logic [WIDX_W-1:0]     lo_word, hi_word;
   logic                  rsp_free;

   assign req_chan.ready           = (state_ff == ST_IDLE);
   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.granted_address = rsp_addr_ff;
   assign rsp_chan.status          = rsp_status_ff;

   assign size_round = {1'b0, req_chan.size_bytes} + ROUND_UP;
   assign end_excl   = CMP_W'(first_ff) + CMP_W'(pages_ff);
   assign lo_word    = lo_ff[PIDX_W-1:LANE_W];
   assign hi_word    = hi_ff[PIDX_W-1:LANE_W];
   assign rsp_free   = !rsp_valid_ff || rsp_chan.ready;

   // Mark lanes past the last page as used so no run extends into them
   always_comb begin : pad_lanes
      for (int b = 0; b < WORD_BITS; b++) begin
         pad_mask[b] = ({1'b0, proc_ff, LANE_W'(b)} >= PAD_START);
      end
   end

   // Lanes of the current word covered by the run being marked or released
   always_comb begin : cover_lanes
      for (int b = 0; b < WORD_BITS; b++) begin
         run_mask[b] = ((proc_ff != lo_word) || (LANE_W'(b) >= lo_ff[LANE_W-1:0])) &&
                       ((proc_ff != hi_word) || (LANE_W'(b) <= hi_ff[LANE_W-1:0]));
      end
   end

   assign scan_word = rd_data_ff | pad_mask;

   bpra_run_scan #(
      .NUM_PAGES (NUM_PAGES)
   ) u_scan (
      .used_word (scan_word),
      .carry_run (carry_ff),
      .pages     (CNT_W'(pages_ff)),
      .carry_out (scan_carry),
      .result    (scan_res)
   );

   // Sequencer: check, scan the map word by word for an allocate, then rewrite the covered words
   always_comb begin : seq_next
      state_in      = state_ff;
      base_in       = base_ff;
      mode_in       = mode_ff;
      size_in       = size_ff;
      addr_in       = addr_ff;
      pages_in      = pages_ff;
      first_in      = first_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      iss_in        = iss_ff;
      proc_in       = proc_ff;
      dv_in         = 1'b0;
      carry_in      = carry_ff;
      clr_in        = clr_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_addr_in   = rsp_addr_ff;
      rsp_status_in = rsp_status_ff;
      rd_en         = 1'b0;
      rd_addr       = iss_ff[WIDX_W-1:0];
      wr_en         = 1'b0;
      wr_addr       = proc_ff;
      wr_data       = '0;

      if (csr_write_enable) begin
         base_in = csr_write_data;
      end

      case (state_ff)
         ST_CLEAR: begin
            // Zero one map word per cycle after reset
            wr_en   = 1'b1;
            wr_addr = clr_ff[WIDX_W-1:0];
            if (clr_ff == LAST_WORD) begin
               state_in = ST_IDLE;
            end else begin
               clr_in = clr_ff + WCNT_W'(1);
            end
         end
         ST_IDLE: begin
            // Capture the transaction and round its size up to pages
            if (req_chan.valid) begin
               mode_in  = req_chan.mode;
               size_in  = req_chan.size_bytes;
               addr_in  = req_chan.region_address;
               pages_in = size_round[SIZE_W:PAGE_SHIFT];
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (size_ff == '0) begin
               status_in = STATUS_ZERO_SIZE;
               state_in  = ST_DONE;
            end else if (mode_ff == MODE_ALLOC) begin
               if (CMP_W'(pages_ff) > NUM_PAGES_C) begin
                  status_in = STATUS_NO_RUN;
                  state_in  = ST_DONE;
               end else begin
                  iss_in   = '0;
                  proc_in  = '0;
                  carry_in = '0;
                  state_in = ST_SEARCH;
               end
            end else if (addr_ff < base_ff) begin
               status_in = STATUS_OUTSIDE;
               state_in  = ST_DONE;
            end else begin
               first_in = FIRST_W'((addr_ff - base_ff) >> PAGE_SHIFT);
               state_in = ST_PREP;
            end
         end
         ST_SEARCH: begin
            // Stream map words into the scan unit, one read ahead
            if (iss_ff <= LAST_WORD) begin
               rd_en  = 1'b1;
               iss_in = iss_ff + WCNT_W'(1);
               dv_in  = 1'b1;
            end
            if (dv_ff) begin
               carry_in = scan_carry;
               if (scan_res.hit) begin
                  hi_in    = {proc_ff, scan_res.lane};
                  state_in = ST_PREP;
               end else if ({1'b0, proc_ff} == LAST_WORD) begin
                  status_in = STATUS_NO_RUN;
                  state_in  = ST_DONE;
               end else begin
                  proc_in = proc_ff + WIDX_W'(1);
               end
            end
         end
         ST_PREP: begin
            // Settle the page range, then start at its first word; a free past the window end is rejected
            if (mode_ff == MODE_ALLOC) begin
               lo_in    = PIDX_W'(CMP_W'(hi_ff) - CMP_W'(pages_ff) + CMP_W'(1));
               iss_in   = {1'b0, lo_in[PIDX_W-1:LANE_W]};
               proc_in  = lo_in[PIDX_W-1:LANE_W];
               state_in = ST_APPLY;
            end else if ((CMP_W'(first_ff) >= NUM_PAGES_C) || (end_excl > NUM_PAGES_C)) begin
               status_in = STATUS_OUTSIDE;
               state_in  = ST_DONE;
            end else begin
               lo_in    = first_ff[PIDX_W-1:0];
               hi_in    = PIDX_W'(end_excl - CMP_W'(1));
               iss_in   = {1'b0, lo_in[PIDX_W-1:LANE_W]};
               proc_in  = lo_in[PIDX_W-1:LANE_W];
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: begin
            // Read ahead one word, set or clear the covered bits of the word in hand
            if (iss_ff <= {1'b0, hi_word}) begin
               rd_en  = 1'b1;
               iss_in = iss_ff + WCNT_W'(1);
               dv_in  = 1'b1;
            end
            if (dv_ff) begin
               wr_en   = 1'b1;
               wr_data = (mode_ff == MODE_FREE) ? (rd_data_ff & ~run_mask)
                                                : (rd_data_ff | run_mask);
               if (proc_ff == hi_word) begin
                  status_in = STATUS_OK;
                  state_in  = ST_DONE;
               end else begin
                  proc_in = proc_ff + WIDX_W'(1);
               end
            end
         end
         ST_DONE: begin
            // Load the output register once it is free
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               if (mode_ff == MODE_ALLOC && status_ff == STATUS_OK) begin
                  rsp_addr_in = base_ff + (ADDR_W'(lo_ff) << PAGE_SHIFT);
               end else begin
                  rsp_addr_in = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
            clr_in   = '0;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         dv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         base_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         dv_ff        <= dv_in;
         rsp_valid_ff <= rsp_valid_in;
         base_ff      <= base_in;
      end
   end

   // Payload and working registers
   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      size_ff       <= size_in;
      addr_ff       <= addr_in;
      pages_ff      <= pages_in;
      first_ff      <= first_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      iss_ff        <= iss_in;
      proc_ff       <= proc_in;
      carry_ff      <= carry_in;
      status_ff     <= status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_status_ff <= rsp_status_in;
   end

   // Usage map: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= map_mem[rd_addr];
      end
      if (wr_en) begin
         map_mem[wr_addr] <= wr_data;
      end
   end

endmodule

### rtl/bpra_checker.sv
// Port-level checks of the bitmap page run allocator, bound to its top level.
// Depends on bpra_pkg for the field widths.
module bpra_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [bpra_pkg::ADDR_W-1:0]   rsp_granted_address,
   input logic [bpra_pkg::STATUS_W-1:0] rsp_status
);

   logic [1:0] pend_ff, pend_in;
   logic       req_acc, rsp_acc;

   assign req_acc = req_valid && req_ready;
   assign rsp_acc = rsp_valid && rsp_ready;

   // Count transactions accepted but not yet answered
   always_comb begin
      pend_in = pend_ff + {1'b0, req_acc} - {1'b0, rsp_acc};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   // Hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_granted_address) && $stable(rsp_status))
      else $error("response changed while stalled");

   // One transaction at a time: busy right after an accept
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> !req_ready)
      else $error("request accepted while busy");

   // Every response answers an accepted request
   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pend_ff != 2'd0)
      else $error("response without a pending request");

   // The map clearing pass holds requests off after reset
   a_clear_after_reset: assert property (@(posedge clock)
      !reset && $past(reset) |-> !req_ready)
      else $error("ready during map clearing");

endmodule

bind bitmap_page_run_allocator bpra_checker u_bpra_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_chan.valid),
   .req_ready           (req_chan.ready),
   .rsp_valid           (rsp_chan.valid),
   .rsp_ready           (rsp_chan.ready),
   .rsp_granted_address (rsp_chan.granted_address),
   .rsp_status          (rsp_chan.status)
);
